### design/catmull_rom_path_walker_defines.svh
// assertion macros for the catmull-rom path walker
// used by the top level, no other dependencies
`ifndef CATMULL_ROM_PATH_WALKER_DEFINES_SVH
`define CATMULL_ROM_PATH_WALKER_DEFINES_SVH
`ifndef SYNTHESIS
`define CRPW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crpw assertion failed");
`define CRPW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crpw assertion failed");
`else
`define CRPW_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CRPW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/crpw_pkg.sv
// shared types, constants and command codes of the catmull-rom path walker
// no dependencies
`default_nettype none

package crpw_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int DATA_W      = 32;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int STEP_W      = 16;
    localparam int CMD_W       = 2;
    localparam int WORD_W      = 3 * DATA_W;
    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = CMD_W;
    localparam int OUT_TDATA_W = WORD_W;
    localparam int OUT_TUSER_W = 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // horner accumulator width and split point of the half-width multiply
    localparam int ACC_W = 38;
    localparam int LO_W  = ACC_W / 2;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_T_STEP      = 2'd1;

    localparam logic [CNT_W-1:0]  POINT_COUNT_RST = 7'd4;
    localparam logic [STEP_W-1:0] T_STEP_RST      = 16'd655;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PT_RD,
        ST_PT_OUT,
        ST_CHECK,
        ST_RD_PREV,
        ST_RD_CUR,
        ST_RD_NEXT,
        ST_RD_NEXT2,
        ST_RD_TAIL,
        ST_PREP,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACCUM,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        SEL_FIRST,
        SEL_LAST,
        SEL_PREV,
        SEL_CUR,
        SEL_NEXT,
        SEL_NEXT2
    } addr_sel_t;

    typedef enum logic [1:0] {
        TERM_C,
        TERM_B,
        TERM_E
    } term_t;

    typedef enum logic {
        SRC_POINT,
        SRC_CURVE
    } out_src_t;

    typedef struct packed {
        logic  shift_en;
        logic  prep_en;
        logic  mul_lo;
        logic  mul_hi;
        logic  acc_en;
        term_t term;
    } lane_cmd_t;

    typedef struct packed {
        logic      wr_en;
        logic      start_clr;
        logic      advance;
        logic      rd_en;
        addr_sel_t rd_sel;
        lane_cmd_t lane;
        logic      out_load;
        out_src_t  out_src;
        logic      out_done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic walk_done;
    } dp_status_t;

endpackage

`default_nettype wire

### design/catmull_rom_path_walker.sv
// catmull-rom path walker top level: controller, datapath and config port
// write: stored when taken; start: first point read, then output load; tick past the end:
// check, last point read, output load; tick on the curve: check, four table reads, one per cycle,
// then three horner steps of two half-width multiplies each and the output load; busy until loaded
// reset clears controller and walk position, presets config; point table undefined until written
`default_nettype none

`include "catmull_rom_path_walker_defines.svh"

module catmull_rom_path_walker #(
    parameter int MAX_POINTS = crpw_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = crpw_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // point_index, in_x, in_y, in_z, zero pad
    input  wire logic [crpw_pkg::IN_TDATA_W-1:0]     s_tdata,
    // cmd
    input  wire logic [crpw_pkg::IN_TUSER_W-1:0]     s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // pos_x, pos_y, pos_z
    output logic      [crpw_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // done_res
    output logic      [crpw_pkg::OUT_TUSER_W-1:0]    m_tuser,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [crpw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [crpw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import crpw_pkg::*;

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    crpw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    crpw_dp #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (ctrl_cmd),
        .status    (dp_status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // a result never overwrites one that is still waiting
    `CRPW_ASSERT_IMPL(a_out_load_free, clk, rst_n, ctrl_cmd.out_load, !m_tvalid || m_tready)
    // a tick keeps the block busy in the following cycle
    `CRPW_ASSERT_NEXT(a_tick_busy, clk, rst_n, s_tvalid && s_tready && s_tuser == CMD_TICK, !s_tready)
    // the high partial product always follows the low one
    `CRPW_ASSERT_IMPL(a_mul_order, clk, rst_n, ctrl_cmd.lane.mul_hi, $past(ctrl_cmd.lane.mul_lo))

endmodule

`default_nettype wire

### design/crpw_lane.sv
// one coordinate lane: neighbor shift line, basis terms and horner evaluation
// depends on crpw_pkg
`default_nettype none

module crpw_lane #(
    parameter int FRAC_BITS = crpw_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire crpw_pkg::lane_cmd_t               cmd,
    input  wire logic        [FRAC_BITS-1:0]       t,
    input  wire logic signed [crpw_pkg::DATA_W-1:0] rd_word,
    output logic signed      [crpw_pkg::DATA_W-1:0] res
);

    import crpw_pkg::*;

    localparam int OP_W = (LO_W + 1 > ACC_W - LO_W) ? LO_W + 1 : ACC_W - LO_W;
    localparam int PR_W = OP_W + FRAC_BITS + 1;
    localparam int P_W  = ACC_W + FRAC_BITS + 1;

    localparam logic signed [P_W-1:0]   HALF   = P_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (DATA_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) <<< (DATA_W - 1));

    logic signed [DATA_W-1:0] p_reg [4];
    logic signed [ACC_W-1:0]  c_reg;
    logic signed [ACC_W-1:0]  b_reg;
    logic signed [ACC_W-1:0]  e_reg;
    logic signed [ACC_W-1:0]  h_reg;
    logic signed [ACC_W-1:0]  h_next;
    logic signed [P_W-1:0]    acc_reg;
    logic signed [P_W-1:0]    acc_next;

    logic signed [ACC_W-1:0]  pe0;
    logic signed [ACC_W-1:0]  pe1;
    logic signed [ACC_W-1:0]  pe2;
    logic signed [ACC_W-1:0]  pe3;
    logic signed [ACC_W-1:0]  diff12;
    logic signed [ACC_W-1:0]  d_val;
    logic signed [ACC_W-1:0]  c_val;
    logic signed [OP_W-1:0]   op;
    logic signed [FRAC_BITS:0] t_s;
    logic signed [PR_W-1:0]   prod;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W-1:0]  h_rnd;
    logic signed [ACC_W-1:0]  h_half;

    assign pe0    = ACC_W'(p_reg[0]);
    assign pe1    = ACC_W'(p_reg[1]);
    assign pe2    = ACC_W'(p_reg[2]);
    assign pe3    = ACC_W'(p_reg[3]);
    assign diff12 = pe1 - pe2;
    assign d_val  = (pe3 - pe0) + diff12 + (diff12 <<< 1);
    assign c_val  = (pe0 <<< 1) - (pe1 <<< 2) - pe1 + (pe2 <<< 2) - pe3;

    // low half unsigned, high half signed
    assign op   = cmd.mul_hi ? OP_W'($signed(h_reg[ACC_W-1:LO_W]))
                             : OP_W'($signed({1'b0, h_reg[LO_W-1:0]}));
    assign t_s  = $signed({1'b0, t});
    assign prod = op * t_s;

    always_comb
    begin
        unique case (cmd.term)
            TERM_C:  addend = c_reg;
            TERM_B:  addend = b_reg;
            TERM_E:  addend = e_reg;
            default: addend = '0;
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.mul_lo)
        begin
            acc_next = P_W'(prod) + HALF;
        end
        else if (cmd.mul_hi)
        begin
            acc_next = acc_reg + (P_W'(prod) <<< LO_W);
        end
    end

    assign h_next = addend + ACC_W'(acc_reg >>> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (cmd.shift_en)
        begin
            p_reg[0] <= p_reg[1];
            p_reg[1] <= p_reg[2];
            p_reg[2] <= p_reg[3];
            p_reg[3] <= rd_word;
        end
        if (cmd.prep_en)
        begin
            h_reg <= d_val;
            c_reg <= c_val;
            b_reg <= pe2 - pe0;
            e_reg <= pe1 <<< 1;
        end
        else if (cmd.acc_en)
        begin
            h_reg <= h_next;
        end
        if (cmd.mul_lo || cmd.mul_hi)
        begin
            acc_reg <= acc_next;
        end
    end

    // round half up, then clamp to 32 bits
    assign h_rnd  = h_reg + ACC_W'(1);
    assign h_half = h_rnd >>> 1;

    always_comb
    begin
        priority if (h_half > SAT_HI)
        begin
            res = SAT_HI[DATA_W-1:0];
        end
        else if (h_half < SAT_LO)
        begin
            res = SAT_LO[DATA_W-1:0];
        end
        else
        begin
            res = h_half[DATA_W-1:0];
        end
    end

endmodule

`default_nettype wire

### design/crpw_dp.sv
// datapath: point table, config registers, walk position, lanes and output register
// depends on crpw_pkg and crpw_lane
`default_nettype none

module crpw_dp #(
    parameter int MAX_POINTS = crpw_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = crpw_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    input  wire logic [crpw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [crpw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [crpw_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire crpw_pkg::ctrl_cmd_t                 cmd,
    output crpw_pkg::dp_status_t                     status,
    output logic      [crpw_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic      [crpw_pkg::OUT_TUSER_W-1:0]    m_tuser
);

    import crpw_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int NW   = ($clog2(MAX_POINTS + 1) > CNT_W) ? $clog2(MAX_POINTS + 1) : CNT_W;
    localparam int XW   = NW + 1;
    localparam int IXW  = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int PH_W = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;

    localparam logic [PH_W-1:0] ONE_T = PH_W'(1) << FRAC_BITS;

    logic [CNT_W-1:0]  point_count_reg;
    logic [CNT_W-1:0]  point_count_next;
    logic [STEP_W-1:0] t_step_reg;
    logic [STEP_W-1:0] t_step_next;
    logic [AW-1:0]     seg_reg;
    logic [AW-1:0]     seg_next;
    logic [PH_W-1:0]   phase_reg;
    logic [PH_W-1:0]   phase_next;
    logic [PH_W-1:0]   phase_sum;

    logic [WORD_W-1:0] mem [MAX_POINTS];
    logic [WORD_W-1:0] rd_word_reg;
    logic [WORD_W-1:0] out_data_reg;
    logic              out_done_reg;

    logic [XW-1:0]     pc_ext;
    logic [XW-1:0]     n_use;
    logic [XW-1:0]     last_idx;
    logic [XW-1:0]     seg_ext;
    logic [XW-1:0]     next2;
    logic [XW-1:0]     next2_cl;
    logic [AW-1:0]     prev_idx;
    logic [AW-1:0]     rd_addr;
    logic [IXW-1:0]    wr_ix;
    logic              wr_ok;
    logic              walk_done;

    logic signed [DATA_W-1:0] lane_res [3];

    // config registers
    always_comb
    begin
        point_count_next = point_count_reg;
        t_step_next      = t_step_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_POINT_COUNT: point_count_next = cfg_data[CNT_W-1:0];
                REG_T_STEP:      t_step_next      = cfg_data[STEP_W-1:0];
                default:         ;
            endcase
        end
    end

    // active count and clamped neighbor indices
    assign pc_ext    = XW'(point_count_reg);
    assign n_use     = (pc_ext == '0) ? XW'(1)
                     : ((pc_ext > XW'(MAX_POINTS)) ? XW'(MAX_POINTS) : pc_ext);
    assign last_idx  = n_use - XW'(1);
    assign seg_ext   = XW'(seg_reg);
    assign walk_done = (seg_ext + XW'(1)) >= n_use;
    assign next2     = seg_ext + XW'(2);
    assign next2_cl  = (next2 >= n_use) ? last_idx : next2;
    assign prev_idx  = (seg_reg == '0) ? '0 : seg_reg - AW'(1);

    assign status.walk_done = walk_done;

    always_comb
    begin
        unique case (cmd.rd_sel)
            SEL_FIRST: rd_addr = '0;
            SEL_LAST:  rd_addr = last_idx[AW-1:0];
            SEL_PREV:  rd_addr = prev_idx;
            SEL_CUR:   rd_addr = seg_reg;
            SEL_NEXT:  rd_addr = seg_reg + AW'(1);
            SEL_NEXT2: rd_addr = next2_cl[AW-1:0];
            default:   rd_addr = '0;
        endcase
    end

    // walk position
    assign phase_sum = phase_reg + PH_W'(t_step_reg);

    always_comb
    begin
        seg_next   = seg_reg;
        phase_next = phase_reg;
        priority if (cmd.start_clr)
        begin
            seg_next   = '0;
            phase_next = '0;
        end
        else if (cmd.advance && !walk_done)
        begin
            if (phase_sum >= ONE_T)
            begin
                seg_next   = seg_reg + AW'(1);
                phase_next = '0;
            end
            else
            begin
                phase_next = phase_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= POINT_COUNT_RST;
            t_step_reg      <= T_STEP_RST;
            seg_reg         <= '0;
            phase_reg       <= '0;
        end
        else
        begin
            point_count_reg <= point_count_next;
            t_step_reg      <= t_step_next;
            seg_reg         <= seg_next;
            phase_reg       <= phase_next;
        end
    end

    // point table, x in the low word
    assign wr_ix = IXW'(s_tdata[IDX_W-1:0]);
    assign wr_ok = wr_ix < IXW'(MAX_POINTS);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_ok)
        begin
            mem[wr_ix[AW-1:0]] <= s_tdata[IDX_W +: WORD_W];
        end
        if (cmd.rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        crpw_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .cmd     (cmd.lane),
            .t       (phase_reg[FRAC_BITS-1:0]),
            .rd_word ($signed(rd_word_reg[g*DATA_W +: DATA_W])),
            .res     (lane_res[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_done_reg <= cmd.out_done;
            if (cmd.out_src == SRC_POINT)
            begin
                out_data_reg <= rd_word_reg;
            end
            else
            begin
                out_data_reg <= {lane_res[2], lane_res[1], lane_res[0]};
            end
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_done_reg;

endmodule

`default_nettype wire

### design/crpw_ctrl.sv
// controller: sequences table reads, horner steps and the output transfer
// depends on crpw_pkg
`default_nettype none

module crpw_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    input  wire logic [crpw_pkg::CMD_W-1:0]   s_cmd,
    output logic                              s_tready,
    input  wire logic                         m_tready,
    output logic                              m_tvalid,
    input  wire crpw_pkg::dp_status_t         status,
    output crpw_pkg::ctrl_cmd_t               cmd
);

    import crpw_pkg::*;

    state_t state_reg;
    state_t state_next;
    term_t  term_reg;
    term_t  term_next;
    logic   done_flag_reg;
    logic   done_flag_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        term_next      = term_reg;
        done_flag_next = done_flag_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (s_cmd)
                        CMD_START:
                        begin
                            state_next     = ST_PT_RD;
                            done_flag_next = 1'b0;
                        end
                        CMD_TICK: state_next = ST_CHECK;
                        default:  ;
                    endcase
                end
            end
            ST_PT_RD:  state_next = ST_PT_OUT;
            ST_PT_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                if (status.walk_done)
                begin
                    state_next     = ST_PT_RD;
                    done_flag_next = 1'b1;
                end
                else
                begin
                    state_next = ST_RD_PREV;
                end
            end
            ST_RD_PREV:  state_next = ST_RD_CUR;
            ST_RD_CUR:   state_next = ST_RD_NEXT;
            ST_RD_NEXT:  state_next = ST_RD_NEXT2;
            ST_RD_NEXT2: state_next = ST_RD_TAIL;
            ST_RD_TAIL:  state_next = ST_PREP;
            ST_PREP:
            begin
                state_next = ST_MUL_LO;
                term_next  = TERM_C;
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_ACCUM;
            ST_ACCUM:
            begin
                if (term_reg == TERM_E)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_MUL_LO;
                    term_next  = (term_reg == TERM_C) ? TERM_B : TERM_E;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.wr_en     = s_tvalid && (s_cmd == CMD_WRITE);
                cmd.start_clr = s_tvalid && (s_cmd == CMD_START);
                cmd.advance   = s_tvalid && (s_cmd == CMD_TICK);
            end
            ST_PT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = done_flag_reg ? SEL_LAST : SEL_FIRST;
            end
            ST_PT_OUT:
            begin
                cmd.out_load = out_free;
                cmd.out_src  = SRC_POINT;
                cmd.out_done = done_flag_reg;
            end
            ST_CHECK: ;
            ST_RD_PREV:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_PREV;
            end
            ST_RD_CUR:
            begin
                cmd.rd_en         = 1'b1;
                cmd.rd_sel        = SEL_CUR;
                cmd.lane.shift_en = 1'b1;
            end
            ST_RD_NEXT:
            begin
                cmd.rd_en         = 1'b1;
                cmd.rd_sel        = SEL_NEXT;
                cmd.lane.shift_en = 1'b1;
            end
            ST_RD_NEXT2:
            begin
                cmd.rd_en         = 1'b1;
                cmd.rd_sel        = SEL_NEXT2;
                cmd.lane.shift_en = 1'b1;
            end
            ST_RD_TAIL: cmd.lane.shift_en = 1'b1;
            ST_PREP:    cmd.lane.prep_en  = 1'b1;
            ST_MUL_LO:  cmd.lane.mul_lo   = 1'b1;
            ST_MUL_HI:  cmd.lane.mul_hi   = 1'b1;
            ST_ACCUM:
            begin
                cmd.lane.acc_en = 1'b1;
                cmd.lane.term   = term_reg;
            end
            ST_FIN:
            begin
                cmd.out_load = out_free;
                cmd.out_src  = SRC_CURVE;
                cmd.out_done = 1'b0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            term_reg      <= TERM_C;
            done_flag_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            term_reg      <= term_next;
            done_flag_reg <= done_flag_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for catmull_rom_path_walker: point writes, walk starts and ticks
// on the stream ports, register writes on the config port, positions predicted in the bench
// depends on crpw_pkg and the catmull_rom_path_walker top level

module tb;
    import crpw_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 9;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 40;
    localparam int ITEM_GOAL   = 425;
    localparam int LONG_HOLD   = 400;

    localparam logic [CMD_W-1:0]         CMD_NONE = 2'd3;
    localparam logic signed [DATA_W-1:0] Q_MAX    = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] Q_MIN    = 32'sh80000000;
    localparam longint                   SAT_HI   = 64'sd2147483647;
    localparam longint                   SAT_LO   = -64'sd2147483648;
    localparam longint                   T_ONE    = 64'sd1 <<< FRAC_BITS_DEF;
    localparam longint                   T_HALF   = 64'sd1 <<< (FRAC_BITS_DEF - 1);

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } path_item_t;

    typedef struct {
        logic [WORD_W-1:0] pos;
        logic              done;
    } position_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    wire logic              s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [IN_TUSER_W-1:0]  s_tuser   = '0;
    wire logic              m_tvalid;
    logic                   m_tready  = 1'b0;
    wire logic [OUT_TDATA_W-1:0] m_tdata;
    wire logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   cfg_valid = 1'b0;
    wire logic              cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    catmull_rom_path_walker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    path_item_t item_queue[$];
    position_t  position_queue[$];
    path_item_t tx_item  = '{CMD_NONE, '0, '0, '0, '0};
    bit         tx_busy  = 1'b0;
    bit         tx_taken = 1'b0;
    bit         steady   = 1'b0;
    int         rx_hold_req  = 0;
    int         rx_hold_left = 0;
    string      axis_name [3] = '{"x", "y", "z"};

    logic signed [DATA_W-1:0] pt_x [MAX_POINTS_DEF];
    logic signed [DATA_W-1:0] pt_y [MAX_POINTS_DEF];
    logic signed [DATA_W-1:0] pt_z [MAX_POINTS_DEF];
    bit                       written [MAX_POINTS_DEF];
    logic [CNT_W-1:0]         count_reg = POINT_COUNT_RST;
    logic [STEP_W-1:0]        step_reg  = T_STEP_RST;
    int                       seg_pos   = 0;
    longint                   phase_acc = 0;

    int errors       = 0;
    int items_in     = 0;
    int results_seen = 0;
    int ends_seen    = 0;
    int reg_writes   = 0;
    int items_made   = 0;
    int stall_cycles = 0;

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int points_used();
        if (count_reg < 1)
            return 1;
        if (count_reg > MAX_POINTS_DEF)
            return MAX_POINTS_DEF;
        return int'(count_reg);
    endfunction

    function automatic int clamp_point(int i, int n);
        return (i < 0) ? 0 : ((i > n - 1) ? n - 1 : i);
    endfunction

    function automatic logic [DATA_W-1:0] spline_axis(longint a0, a1, a2, a3, t);
        longint d, c, b, h2, h1, h0, r;
        d  = -a0 + 3 * a1 - 3 * a2 + a3;
        c  = 2 * a0 - 5 * a1 + 4 * a2 - a3;
        b  = a2 - a0;
        h2 = c + ((d * t + T_HALF) >>> FRAC_BITS_DEF);
        h1 = b + ((h2 * t + T_HALF) >>> FRAC_BITS_DEF);
        h0 = 2 * a1 + ((h1 * t + T_HALF) >>> FRAC_BITS_DEF);
        r  = (h0 + 1) >>> 1;
        if (r > SAT_HI)
            r = SAT_HI;
        else if (r < SAT_LO)
            r = SAT_LO;
        return r[DATA_W-1:0];
    endfunction

    function automatic position_t corner(int i, logic done);
        position_t r;
        r.pos  = {pt_z[i], pt_y[i], pt_x[i]};
        r.done = done;
        return r;
    endfunction

    function automatic void walk_apply(path_item_t it);
        int        n;
        int        i0, i1, i2, i3;
        position_t r;
        n = points_used();
        case (it.cmd)
            CMD_WRITE:
            begin
                pt_x[it.idx] = it.x;
                pt_y[it.idx] = it.y;
                pt_z[it.idx] = it.z;
            end
            CMD_START:
            begin
                seg_pos   = 0;
                phase_acc = 0;
                position_queue.push_back(corner(0, 1'b0));
            end
            CMD_TICK:
            begin
                if (seg_pos + 1 < n)
                begin
                    phase_acc += step_reg;
                    if (phase_acc >= T_ONE)
                    begin
                        phase_acc = 0;
                        seg_pos++;
                    end
                end
                if (seg_pos + 1 >= n)
                    position_queue.push_back(corner(n - 1, 1'b1));
                else
                begin
                    i0 = clamp_point(seg_pos - 1, n);
                    i1 = clamp_point(seg_pos, n);
                    i2 = clamp_point(seg_pos + 1, n);
                    i3 = clamp_point(seg_pos + 2, n);
                    r.pos = {spline_axis(pt_z[i0], pt_z[i1], pt_z[i2], pt_z[i3], phase_acc),
                             spline_axis(pt_y[i0], pt_y[i1], pt_y[i2], pt_y[i3], phase_acc),
                             spline_axis(pt_x[i0], pt_x[i1], pt_x[i2], pt_x[i3], phase_acc)};
                    r.done = 1'b0;
                    position_queue.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] any_coord();
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3, 4: return $signed(DATA_W'($urandom_range(32'h000fffff))) - 32'sh00080000;
            default: return $signed(DATA_W'($urandom));
        endcase
    endfunction

    function automatic void put_item(logic [CMD_W-1:0] cmd, int idx,
                                     logic signed [DATA_W-1:0] x, y, z);
        path_item_t it;
        it.cmd = cmd;
        it.idx = IDX_W'(idx);
        it.x   = x;
        it.y   = y;
        it.z   = z;
        item_queue.push_back(it);
        if (cmd == CMD_WRITE)
            written[it.idx] = 1'b1;
        if (cmd != CMD_NONE)
            items_made++;
    endfunction

    function automatic void put_point(int idx);
        put_item(CMD_WRITE, idx, any_coord(), any_coord(), any_coord());
    endfunction

    // start and tick read entries 0..n-1, so fill any gaps first
    function automatic void put_walk(logic [CMD_W-1:0] cmd);
        for (int i = 0; i < points_used(); i++)
            if (!written[i])
                put_point(i);
        put_item(cmd, $urandom_range(MAX_POINTS_DEF - 1), any_coord(), any_coord(), any_coord());
    endfunction

    task automatic wait_quiet();
        while (item_queue.size() != 0 || tx_busy || position_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (ri == REG_POINT_COUNT)
            count_reg = val[CNT_W-1:0];
        else
            step_reg = val;
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(int cnt, int step);
        wait_quiet();
        reg_write(REG_POINT_COUNT, CFG_DATA_W'(cnt));
        reg_write(REG_T_STEP, CFG_DATA_W'(step));
    endtask

    task automatic random_phase(int cnt, int step, bit calm, int hold);
        int stop_at;
        int n;
        set_regs(cnt, step);
        steady  = calm;
        stop_at = items_made + $urandom_range(30, 60);
        while (items_made < stop_at)
        begin
            n = points_used();
            if ($urandom_range(99) < 75)
            begin
                repeat ($urandom_range(3)) put_point($urandom_range(n - 1));
                if ($urandom_range(99) < 80)
                    put_walk(CMD_START);
                repeat ($urandom_range(3, 20)) put_walk(CMD_TICK);
            end
            else
            begin
                case ($urandom_range(3))
                    0: put_point($urandom_range(MAX_POINTS_DEF - 1));
                    1: put_item(CMD_NONE, $urandom_range(MAX_POINTS_DEF - 1),
                                any_coord(), any_coord(), any_coord());
                    2: put_walk(CMD_START);
                    default: put_walk(CMD_TICK);
                endcase
            end
        end
        if (hold > 0)
            rx_hold_req = hold;
    endtask

    // input side: one item presented at a time, gaps only before a new item
    always @(negedge clk)
    begin
        if (tx_taken)
        begin
            tx_busy  = 1'b0;
            tx_taken = 1'b0;
        end
        if (!tx_busy && item_queue.size() != 0 && (steady || $urandom_range(99) >= 14))
        begin
            tx_item = item_queue.pop_front();
            tx_busy = 1'b1;
        end
        s_tvalid <= tx_busy;
        s_tdata  <= {{(IN_TDATA_W - 3 * DATA_W - IDX_W){1'b0}},
                     tx_item.z, tx_item.y, tx_item.x, tx_item.idx};
        s_tuser  <= tx_item.cmd;
    end

    always @(negedge clk)
    begin
        if (rx_hold_req > 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= steady || ($urandom_range(99) >= 14);
    end

    always @(posedge clk)
    begin
        position_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                walk_apply(tx_item);
                tx_taken = 1'b1;
                items_in++;
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (position_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got pos %h done %b",
                             $time, m_tdata, m_tuser);
                    errors++;
                end
                else
                begin
                    want = position_queue.pop_front();
                    if (want.done)
                        ends_seen++;
                    for (int k = 0; k < 3; k++)
                        if (m_tdata[k*DATA_W +: DATA_W] !== want.pos[k*DATA_W +: DATA_W])
                        begin
                            $display("%0t: pos_%s mismatch, expected %h, got %h", $time,
                                     axis_name[k], want.pos[k*DATA_W +: DATA_W],
                                     m_tdata[k*DATA_W +: DATA_W]);
                            errors++;
                        end
                    if (m_tuser[0] !== want.done)
                    begin
                        $display("%0t: done_res mismatch, expected %b, got %b",
                                 $time, want.done, m_tuser[0]);
                        errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    always @(posedge clk)
    begin
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int phase_no;
        int cnt;
        int step;
        phase_no = 0;
        repeat (RESET_LEN) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // alternating extremes force overshoot and saturation
        put_item(CMD_WRITE, 0, Q_MAX, Q_MIN, 32'sd0);
        put_item(CMD_WRITE, 1, Q_MIN, Q_MAX, -32'sd1);
        put_item(CMD_WRITE, 2, Q_MAX, Q_MIN, 32'sd1);
        put_item(CMD_WRITE, 3, Q_MIN, Q_MAX, 32'sh12345678);
        put_item(CMD_WRITE, MAX_POINTS_DEF - 1, Q_MIN, Q_MAX, -32'sd1);
        put_item(CMD_NONE, MAX_POINTS_DEF - 1, -32'sd1, -32'sd1, -32'sd1);
        put_walk(CMD_TICK);
        put_walk(CMD_START);
        put_walk(CMD_TICK);
        put_walk(CMD_TICK);

        // half steps through every segment, then ticks past the end
        set_regs(4, 32768);
        put_walk(CMD_START);
        repeat (7) put_walk(CMD_TICK);

        set_regs(4, 0);
        put_walk(CMD_START);
        repeat (2) put_walk(CMD_TICK);

        set_regs(2, 40000);
        put_walk(CMD_START);
        repeat (3) put_walk(CMD_TICK);

        set_regs(0, 1000);
        put_walk(CMD_START);
        put_walk(CMD_TICK);

        while (items_made < ITEM_GOAL)
        begin
            case (phase_no)
                0:
                begin
                    cnt  = 127;
                    step = 65535;
                end
                1:
                begin
                    cnt  = 3;
                    step = $urandom_range(1, 255);
                end
                2:
                begin
                    cnt  = 64;
                    step = 20000;
                end
                3:
                begin
                    cnt  = 4;
                    step = $urandom_range(4000, 65535);
                end
                default:
                begin
                    case ($urandom_range(7))
                        0: cnt = 1;
                        1: cnt = 2;
                        2: cnt = 3;
                        3: cnt = 64;
                        4: cnt = $urandom_range(65, 127);
                        default: cnt = $urandom_range(3, 64);
                    endcase
                    case ($urandom_range(5))
                        0: step = 65535;
                        1: step = $urandom_range(1, 255);
                        default: step = $urandom_range(4000, 65535);
                    endcase
                end
            endcase
            random_phase(cnt, step, phase_no == 2, (phase_no == 3) ? LONG_HOLD : 0);
            phase_no++;
        end
        wait_quiet();

        $display("walk check: %0d items taken, %0d positions compared, %0d at the path end",
                 items_in, results_seen, ends_seen);
        $display("walk check: %0d register writes, %0d random phases", reg_writes, phase_no);
        if (errors == 0 && position_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
